FILE: hdl/polygon_point_containment_defines.svh
// Assertion macros used by the checker of the polygon containment block.
`ifndef POLYGON_POINT_CONTAINMENT_DEFINES_SVH
`define POLYGON_POINT_CONTAINMENT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ppc check failed");

// Consequent must hold in the cycle after the antecedent.
`define PPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ppc check failed");

`endif

FILE: hdl/ppc_pkg.sv
// Shared constants, types and codes of the polygon containment block.
package ppc_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_W    = 24;
	localparam int ACTION_W   = 3;
	localparam int INDEX_W    = 7;
	localparam int STATUS_W   = 2;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int POS_W      = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic [POS_W-1:0]          pos_t;
	typedef logic [CNT_W-1:0]          count_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_QUERY  = 3'd0,
		ACT_APPEND = 3'd1,
		ACT_SET    = 3'd2,
		ACT_INSERT = 3'd3,
		ACT_DELETE = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vertex_t;

	// Control broadcast to every cell of the vertex chain
	typedef struct packed {
		cell_op_t op;
		pos_t     pos;
		pos_t     last;
	} cell_ctrl_t;

	// Control of the crossing evaluator
	typedef struct packed {
		logic clear;
		logic vld;
		logic first;
	} eval_ctrl_t;

endpackage

FILE: hdl/ppc_stream_if.sv
// Valid/ready channel interfaces for query and edit items and their results.
interface ppc_in_if;
	import ppc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [INDEX_W-1:0]    vertex_index;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
	modport sink (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

interface ppc_out_if;
	import ppc_pkg::*;
	logic                valid;
	logic                ready;
	logic                inside_res;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    vertex_total;
	modport source (output valid, inside_res, status, vertex_total, input ready);
	modport sink (input valid, inside_res, status, vertex_total, output ready);
endinterface

FILE: hdl/ppc_cell.sv
// One vertex cell of the chain: loads, shifts toward either neighbor, or rotates.
module ppc_cell (
	input  logic               clk,
	input  ppc_pkg::pos_t      idx,
	input  ppc_pkg::cell_ctrl_t ctrl,
	input  ppc_pkg::vertex_t   new_v,
	input  ppc_pkg::vertex_t   left_v,
	input  ppc_pkg::vertex_t   right_v,
	input  ppc_pkg::vertex_t   head_v,
	output ppc_pkg::vertex_t   v
);
	import ppc_pkg::*;

	vertex_t vtx_q;

	// Update the held vertex from the broadcast command
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_LOAD: begin
				if (idx == ctrl.pos) vtx_q <= new_v;
			end
			CELL_INSERT: begin
				if (idx == ctrl.pos) vtx_q <= new_v;
				else if (idx > ctrl.pos) vtx_q <= left_v;
			end
			CELL_DELETE: begin
				if (idx >= ctrl.pos) vtx_q <= right_v;
			end
			CELL_ROTATE: begin
				if (idx == ctrl.last) vtx_q <= head_v;
				else if (idx < ctrl.last) vtx_q <= right_v;
			end
			default: begin
			end
		endcase
	end

	assign v = vtx_q;

endmodule

FILE: hdl/ppc_eval.sv
// Bounding box and pipelined even-odd crossing evaluator fed one vertex per cycle.
module ppc_eval (
	input  logic                clk,
	input  logic                arst_n,
	input  ppc_pkg::eval_ctrl_t ctrl,
	input  ppc_pkg::vertex_t    cur,
	input  ppc_pkg::coord_t     px,
	input  ppc_pkg::coord_t     py,
	output logic                in_poly
);
	import ppc_pkg::*;

	vertex_t prev_q;
	coord_t  lox_q, hix_q, loy_q, hiy_q;
	logic    vld_s1, vld_s2, parity_q;
	logic    cross_s1, cross_s2, dyneg_s1, dyneg_s2;
	diff_t   dx_s1, a_s1, b_s1, dy_s1;
	prod_t   p1_s2, p2_s2;
	logic    cross_c, tog_c, inbox_c;

	// Edge straddles the ray's y under the half-open rule
	assign cross_c = (prev_q.y < py) != (cur.y < py);

	// Track previous vertex and bounding box
	always_ff @(posedge clk) begin
		if (ctrl.vld) begin
			prev_q <= cur;
			if (ctrl.first) begin
				lox_q <= cur.x;
				hix_q <= cur.x;
				loy_q <= cur.y;
				hiy_q <= cur.y;
			end else begin
				if (cur.x < lox_q) lox_q <= cur.x;
				if (cur.x > hix_q) hix_q <= cur.x;
				if (cur.y < loy_q) loy_q <= cur.y;
				if (cur.y > hiy_q) hiy_q <= cur.y;
			end
		end
	end

	// Stage 1: differences; stage 2: cross products
	always_ff @(posedge clk) begin
		dx_s1    <= diff_t'(cur.x) - diff_t'(prev_q.x);
		a_s1     <= diff_t'(py) - diff_t'(prev_q.y);
		b_s1     <= diff_t'(px) - diff_t'(prev_q.x);
		dy_s1    <= diff_t'(cur.y) - diff_t'(prev_q.y);
		cross_s1 <= cross_c;
		dyneg_s1 <= cur.y < prev_q.y;
		p1_s2    <= dx_s1 * a_s1;
		p2_s2    <= b_s1 * dy_s1;
		cross_s2 <= cross_s1;
		dyneg_s2 <= dyneg_s1;
	end

	// Toggle when the intersection lies at or right of the point
	assign tog_c = dyneg_s2 ? (p1_s2 <= p2_s2) : (p1_s2 >= p2_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			parity_q <= 1'b0;
		end else begin
			vld_s1 <= ctrl.vld && !ctrl.first;
			vld_s2 <= vld_s1;
			if (ctrl.clear) parity_q <= 1'b0;
			else if (vld_s2 && cross_s2 && tog_c) parity_q <= !parity_q;
		end
	end

	assign inbox_c = (px >= lox_q) && (px <= hix_q) && (py >= loy_q) && (py <= hiy_q);
	assign in_poly = parity_q && inbox_c;

endmodule

FILE: hdl/polygon_point_containment.sv
// Top level: polygon vertex chain with edit sequencer and point query walk.
//
// Items arrive on the item channel (valid/ready): action, vertex_index,
// coord_x, coord_y. Each item yields exactly one result on the result
// channel: inside_res, status, vertex_total. One item is in work at a time.
// An edit (append, set, insert, delete) goes through the execute and
// response states before its result is valid; an insert or delete shifts
// the cells from the edited index on by one place toward a neighbor. A
// query walks the N stored vertices: the chain rotates one vertex per cycle
// past the crossing evaluator at its head, whose difference, product and
// parity registers then drain. A query on an empty polygon skips the walk.
// The result sits in an output register; a new item is taken while it waits,
// and the next result is held back until the receiver takes the old one.
// Reset clears the vertex count and all handshake state; vertex contents
// are undefined until written. No clearing pass is needed.
module polygon_point_containment (
	input logic      clk,
	input logic      arst_n,
	ppc_in_if.sink   item,
	ppc_out_if.source result
);
	import ppc_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WALK, S_DRAIN, S_RESP} state_t;

	state_t               state_q;
	count_t               count_q, walk_q;
	logic [1:0]           drain_q;
	logic [ACTION_W-1:0]  act_q;
	logic [INDEX_W-1:0]   pos_q;
	coord_t               x_q, y_q;
	status_t              pend_status_q;
	logic                 res_valid_q, res_inside_q;
	status_t              res_status_q;
	count_t               res_total_q;

	cell_ctrl_t cell_ctrl;
	eval_ctrl_t eval_ctrl;
	vertex_t    new_v;
	vertex_t    cell_v [MAX_POINTS];
	logic       ev_inside;

	pos_t       k_c, n_c;
	logic       full_c, inc_c, dec_c;
	status_t    status_c;
	cell_op_t   op_c;
	pos_t       op_pos_c;

	assign k_c    = pos_t'(pos_q);
	assign n_c    = pos_t'(count_q);
	assign full_c = count_q == count_t'(MAX_POINTS);
	assign new_v  = '{x: x_q, y: y_q};

	// Decode the edit against the current count
	always_comb begin
		status_c = ST_DONE;
		op_c     = CELL_HOLD;
		op_pos_c = n_c;
		inc_c    = 1'b0;
		dec_c    = 1'b0;
		case (act_q)
			ACT_APPEND: begin
				if (full_c) status_c = ST_FULL;
				else begin
					op_c  = CELL_LOAD;
					inc_c = 1'b1;
				end
			end
			ACT_SET: begin
				if (k_c == n_c) begin
					if (full_c) status_c = ST_FULL;
					else begin
						op_c  = CELL_LOAD;
						inc_c = 1'b1;
					end
				end else if (k_c > n_c) status_c = ST_RANGE;
				else begin
					op_c     = CELL_LOAD;
					op_pos_c = k_c;
				end
			end
			ACT_INSERT: begin
				if (k_c == n_c) begin
					if (full_c) status_c = ST_FULL;
					else begin
						op_c  = CELL_LOAD;
						inc_c = 1'b1;
					end
				end else if (k_c > n_c) status_c = ST_RANGE;
				else if (full_c) status_c = ST_FULL;
				else begin
					op_c     = CELL_INSERT;
					op_pos_c = k_c;
					inc_c    = 1'b1;
				end
			end
			ACT_DELETE: begin
				if (k_c >= n_c) status_c = ST_RANGE;
				else begin
					op_c     = CELL_DELETE;
					op_pos_c = k_c;
					dec_c    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Drive chain and evaluator commands
	always_comb begin
		cell_ctrl.op   = CELL_HOLD;
		cell_ctrl.pos  = op_pos_c;
		cell_ctrl.last = n_c - pos_t'(1);
		eval_ctrl      = '0;
		case (state_q)
			S_EXEC: begin
				cell_ctrl.op    = op_c;
				eval_ctrl.clear = 1'b1;
			end
			S_WALK: begin
				if (walk_q < count_q) cell_ctrl.op = CELL_ROTATE;
				eval_ctrl.vld   = 1'b1;
				eval_ctrl.first = walk_q == '0;
			end
			default: begin
			end
		endcase
	end

	// Vertex chain
	for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
		vertex_t left_v, right_v;
		if (g == 0) begin : g_head
			assign left_v = new_v;
		end else begin : g_mid_l
			assign left_v = cell_v[g-1];
		end
		if (g == MAX_POINTS - 1) begin : g_tail
			assign right_v = cell_v[g];
		end else begin : g_mid_r
			assign right_v = cell_v[g+1];
		end
		ppc_cell u_cell (
			.clk     (clk),
			.idx     (pos_t'(g)),
			.ctrl    (cell_ctrl),
			.new_v   (new_v),
			.left_v  (left_v),
			.right_v (right_v),
			.head_v  (cell_v[0]),
			.v       (cell_v[g])
		);
	end

	ppc_eval u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (eval_ctrl),
		.cur     (cell_v[0]),
		.px      (x_q),
		.py      (y_q),
		.in_poly (ev_inside)
	);

	assign item.ready = state_q == S_IDLE;

	// Capture the item payload on transfer
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			act_q <= item.action;
			pos_q <= item.vertex_index;
			x_q   <= item.coord_x;
			y_q   <= item.coord_y;
		end
	end

	// Sequencer, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			walk_q        <= '0;
			drain_q       <= '0;
			pend_status_q <= ST_DONE;
			res_valid_q   <= 1'b0;
			res_inside_q  <= 1'b0;
			res_status_q  <= ST_DONE;
			res_total_q   <= '0;
		end else begin
			// Drop a taken result unless a new one loads this cycle
			if (result.ready && state_q != S_RESP) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item.valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					pend_status_q <= status_c;
					walk_q        <= '0;
					if (inc_c) count_q <= count_q + count_t'(1);
					else if (dec_c) count_q <= count_q - count_t'(1);
					if (act_q == ACT_QUERY && count_q != '0) state_q <= S_WALK;
					else state_q <= S_RESP;
				end
				S_WALK: begin
					walk_q <= walk_q + count_t'(1);
					if (walk_q == count_q) begin
						drain_q <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2) state_q <= S_RESP;
				end
				S_RESP: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q  <= 1'b1;
						res_inside_q <= (act_q == ACT_QUERY) && (count_q != '0) && ev_inside;
						res_status_q <= pend_status_q;
						res_total_q  <= count_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid        = res_valid_q;
	assign result.inside_res   = res_inside_q;
	assign result.status       = res_status_q;
	assign result.vertex_total = res_total_q;

endmodule

FILE: hdl/ppc_checker.sv
// Port-level checker for the polygon containment block, with its bind.
`include "polygon_point_containment_defines.svh"

module ppc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         inside_res,
	input logic [ppc_pkg::STATUS_W-1:0] status,
	input logic [ppc_pkg::CNT_W-1:0]    vertex_total
);
	import ppc_pkg::*;

	// Count never passes the store size
	`PPC_ASSERT_NOW(a_total_bound, clk, arst_n, out_valid, vertex_total <= CNT_W'(MAX_POINTS))
	// Only defined status codes leave the block
	`PPC_ASSERT_NOW(a_status_code, clk, arst_n, out_valid, status != 2'd3)
	// An inside answer never comes with an error status
	`PPC_ASSERT_NOW(a_inside_ok, clk, arst_n, out_valid && inside_res, status == ST_DONE)
	// Hold a stalled result
	`PPC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(inside_res) && $stable(vertex_total))

endmodule

bind polygon_point_containment ppc_checker u_ppc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.inside_res   (result.inside_res),
	.status       (result.status),
	.vertex_total (result.vertex_total)
);

FILE: sim/polygon_point_containment_test.sv
// Testbench for the polygon containment block: directed and randomized edits and queries checked against a predictor.
module polygon_point_containment_test;
	import ppc_pkg::*;

	typedef struct {
		logic [ACTION_W-1:0] act;
		logic [INDEX_W-1:0]  ndx;
		coord_t              x;
		coord_t              y;
		logic                hold;
	} edit_item_t;

	typedef struct {
		logic                in_poly;
		logic [STATUS_W-1:0] st;
		logic [CNT_W-1:0]    total;
	} answer_t;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	ppc_in_if  item_ch ();
	ppc_out_if result_ch ();

	polygon_point_containment u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.source)
	);

	edit_item_t  pending_items[$];
	answer_t     expected_answers[$];
	coord_t      poly_x[MAX_POINTS];
	coord_t      poly_y[MAX_POINTS];
	int          poly_count;
	int          error_count;
	int          idle_cycles;
	bit          stimulus_done;
	int          burst_left;
	int          gap_left;
	logic [7:0]  stall_pattern;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Sign of a*b - c*d, exact at 64 bits
	function automatic int cross_sign(longint a, longint b, longint c, longint d);
		longint p;
		longint q;
		p = a * b;
		q = c * d;
		return (p > q) ? 1 : ((p < q) ? -1 : 0);
	endfunction

	// Even-odd crossing test with bounding box rejection
	function automatic logic point_inside(longint px, longint py);
		longint lox, hix, loy, hiy, x1, y1, x2, y2, dx, dy;
		int j;
		int c;
		logic ins;
		ins = 1'b0;
		if (poly_count == 0)
			return 1'b0;
		lox = poly_x[0]; hix = lox; loy = poly_y[0]; hiy = loy;
		for (int i = 1; i < poly_count; i++) begin
			if (poly_x[i] < lox) lox = poly_x[i];
			if (poly_x[i] > hix) hix = poly_x[i];
			if (poly_y[i] < loy) loy = poly_y[i];
			if (poly_y[i] > hiy) hiy = poly_y[i];
		end
		if (px < lox || py < loy || px > hix || py > hiy)
			return 1'b0;
		for (int i = 0; i < poly_count; i++) begin
			j = (i + 1 == poly_count) ? 0 : i + 1;
			x1 = poly_x[i]; y1 = poly_y[i]; x2 = poly_x[j]; y2 = poly_y[j];
			if (y1 == y2) continue;
			if (y1 < py && y2 < py) continue;
			if (y1 >= py && y2 >= py) continue;
			dx = x2 - x1;
			dy = y2 - y1;
			c = cross_sign(dx, py - y1, px - x1, dy);
			if ((dy > 0 && c >= 0) || (dy < 0 && c <= 0))
				ins = ~ins;
		end
		return ins;
	endfunction

	function automatic logic [STATUS_W-1:0] add_vertex(coord_t x, coord_t y);
		if (poly_count >= MAX_POINTS)
			return ST_FULL;
		poly_x[poly_count] = x;
		poly_y[poly_count] = y;
		poly_count++;
		return ST_DONE;
	endfunction

	// Apply one item to the polygon copy and return its answer
	function automatic answer_t polygon_update(edit_item_t it);
		answer_t a;
		int n;
		a.in_poly = 1'b0;
		a.st = ST_DONE;
		n = it.ndx;
		case (it.act)
			ACT_QUERY: a.in_poly = point_inside(it.x, it.y);
			ACT_APPEND: a.st = add_vertex(it.x, it.y);
			ACT_SET: begin
				if (n == poly_count) a.st = add_vertex(it.x, it.y);
				else if (n > poly_count) a.st = ST_RANGE;
				else begin
					poly_x[n] = it.x;
					poly_y[n] = it.y;
				end
			end
			ACT_INSERT: begin
				if (n == poly_count) a.st = add_vertex(it.x, it.y);
				else if (n > poly_count) a.st = ST_RANGE;
				else if (poly_count >= MAX_POINTS) a.st = ST_FULL;
				else begin
					for (int i = poly_count; i > n; i--) begin
						poly_x[i] = poly_x[i-1];
						poly_y[i] = poly_y[i-1];
					end
					poly_x[n] = it.x;
					poly_y[n] = it.y;
					poly_count++;
				end
			end
			ACT_DELETE: begin
				if (n >= poly_count) a.st = ST_RANGE;
				else begin
					for (int i = n; i + 1 < poly_count; i++) begin
						poly_x[i] = poly_x[i+1];
						poly_y[i] = poly_y[i+1];
					end
					poly_count--;
				end
			end
			default: ;
		endcase
		a.total = poly_count[CNT_W-1:0];
		return a;
	endfunction

	function automatic edit_item_t make_item(int act, int ndx, int x, int y);
		edit_item_t it;
		it.act = act[ACTION_W-1:0];
		it.ndx = ndx[INDEX_W-1:0];
		it.x = x[COORD_W-1:0];
		it.y = y[COORD_W-1:0];
		it.hold = 1'b0;
		return it;
	endfunction

	function automatic int rand_coord(int span);
		return $urandom_range(2 * span) - span;
	endfunction

	// Fill the pending queue: directed part, then random polygons and queries
	initial begin
		edit_item_t it;
		int cnt;
		int span;
		int nverts;
		int r;
		stimulus_done = 1'b0;
		// Query and delete on an empty store, then out-of-range set and insert
		pending_items.push_back(make_item(ACT_QUERY, 0, 0, 0));
		pending_items.push_back(make_item(ACT_DELETE, 0, 0, 0));
		pending_items.push_back(make_item(ACT_SET, 1, 5, 5));
		pending_items.push_back(make_item(ACT_INSERT, 3, 5, 5));
		// Extreme square, then queries on edges, corners and center, edits and unknown action codes
		pending_items.push_back(make_item(ACT_APPEND, 0, -8388607, -8388607));
		pending_items.push_back(make_item(ACT_QUERY, 0, -8388607, -8388607));
		pending_items.push_back(make_item(ACT_SET, 1, 8388607, -8388607));
		pending_items.push_back(make_item(ACT_INSERT, 2, 8388607, 8388607));
		pending_items.push_back(make_item(ACT_APPEND, 0, -8388607, 8388607));
		pending_items.push_back(make_item(ACT_QUERY, 0, 0, 0));
		pending_items.push_back(make_item(ACT_QUERY, 0, 8388607, 0));
		pending_items.push_back(make_item(ACT_QUERY, 0, -8388607, 0));
		pending_items.push_back(make_item(ACT_QUERY, 0, 0, 8388607));
		pending_items.push_back(make_item(ACT_QUERY, 0, 0, -8388607));
		pending_items.push_back(make_item(ACT_QUERY, 0, -8388608, 0));
		pending_items.push_back(make_item(ACT_SET, 1, 0, -8388607));
		pending_items.push_back(make_item(ACT_QUERY, 0, 100, -100));
		pending_items.push_back(make_item(ACT_INSERT, 1, 0, 0));
		pending_items.push_back(make_item(ACT_DELETE, 4, 0, 0));
		pending_items.push_back(make_item(ACT_DELETE, 1, 0, 0));
		pending_items.push_back(make_item(5, 127, -1, -1));
		pending_items.push_back(make_item(7, 0, 0, 0));
		// Fill to full, overflow by append, set and insert, then query and delete down to empty
		for (int i = 3; i < MAX_POINTS; i++)
			pending_items.push_back(make_item(ACT_APPEND, 0, rand_coord(1000), rand_coord(1000)));
		pending_items.push_back(make_item(ACT_APPEND, 0, 1, 1));
		pending_items.push_back(make_item(ACT_SET, MAX_POINTS, 1, 1));
		pending_items.push_back(make_item(ACT_INSERT, 0, 1, 1));
		pending_items.push_back(make_item(ACT_INSERT, MAX_POINTS, 1, 1));
		pending_items.push_back(make_item(ACT_QUERY, 0, 3, 3));
		it = make_item(ACT_DELETE, MAX_POINTS - 1, 0, 0);
		it.hold = 1'b1;
		pending_items.push_back(it);
		for (int i = 0; i < MAX_POINTS - 1; i++)
			pending_items.push_back(make_item(ACT_DELETE, $urandom_range(MAX_POINTS - 2 - i), 0, 0));
		// Random polygons: build small, edit, query many points
		cnt = 0;
		while (cnt < 640) begin
			span = ($urandom_range(3) == 0) ? 8388607 : (($urandom_range(1)) ? 20 : 2000);
			nverts = ($urandom_range(7) == 0) ? $urandom_range(20, MAX_POINTS)
				: $urandom_range(0, 8);
			for (int i = 0; i < nverts; i++) begin
				pending_items.push_back(make_item(ACT_APPEND, 0, rand_coord(span),
					rand_coord(span)));
				cnt++;
			end
			for (int k = 0; k < 12; k++) begin
				r = $urandom_range(15);
				if (r < 9)
					it = make_item(ACT_QUERY, $urandom_range(127), rand_coord(span),
						rand_coord(span));
				else if (r < 13)
					it = make_item($urandom_range(2, 4), $urandom_range(nverts + 1),
						rand_coord(span), rand_coord(span));
				else
					it = make_item($urandom_range(7), $urandom_range(127),
						$urandom, $urandom);
				pending_items.push_back(it);
				cnt++;
			end
			// Shrink the store, deleting nverts + 4 times from random places near the front
			for (int i = 0; i < nverts + 4; i++)
				pending_items.push_back(make_item(ACT_DELETE, $urandom_range(1), 0, 0));
			cnt += nverts + 4;
		end
		stimulus_done = 1'b1;
	end

	// Reset and run-end control
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (stimulus_done && pending_items.size() == 0 && !item_ch.valid
			&& expected_answers.size() == 0);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Driver: bursts with random gaps; hold items wait for an empty result queue
	initial begin
		item_ch.valid = 1'b0;
		item_ch.action = '0;
		item_ch.vertex_index = '0;
		item_ch.coord_x = '0;
		item_ch.coord_y = '0;
		burst_left = 0;
		gap_left = 0;
		poly_count = 0;
		error_count = 0;
	end

	always @(posedge clk) begin
		edit_item_t it;
		answer_t ans;
		logic take_next;
		if (arst_n) begin
			take_next = !item_ch.valid || item_ch.ready;
			if (item_ch.valid && item_ch.ready) begin
				it.act = item_ch.action;
				it.ndx = item_ch.vertex_index;
				it.x = item_ch.coord_x;
				it.y = item_ch.coord_y;
				ans = polygon_update(it);
				expected_answers.push_back(ans);
			end
			if (take_next) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					item_ch.valid <= 1'b0;
				end else if (pending_items.size() != 0 && !(pending_items[0].hold
					&& (expected_answers.size() != 0 || item_ch.valid))) begin
					it = pending_items.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.action <= it.act;
					item_ch.vertex_index <= it.ndx;
					item_ch.coord_x <= it.x;
					item_ch.coord_y <= it.y;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 80);
					end else
						burst_left <= burst_left - 1;
				end else
					item_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern: rotating mask, reloaded now and then
	initial begin
		result_ch.ready = 1'b0;
		stall_pattern = 8'hff;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ($urandom_range(63) == 0)
				stall_pattern <= ($urandom_range(2) == 0) ? 8'hff : 8'($urandom);
			else
				stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
			result_ch.ready <= stall_pattern[0];
		end
	end

	// Monitor: compare each result transfer with the oldest expected answer
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected result inside=%0b status=%0d total=%0d", $time,
						result_ch.inside_res, result_ch.status, result_ch.vertex_total);
					error_count++;
				end else begin
					want = expected_answers.pop_front();
					if (result_ch.inside_res !== want.in_poly) begin
						$display("%0t: inside_res expected %0b actual %0b", $time,
							want.in_poly, result_ch.inside_res);
						error_count++;
					end
					if (result_ch.status !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.st, result_ch.status);
						error_count++;
					end
					if (result_ch.vertex_total !== want.total) begin
						$display("%0t: vertex_total expected %0d actual %0d", $time,
							want.total, result_ch.vertex_total);
						error_count++;
					end
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready)
			|| (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ppc_pkg.sv
hdl/ppc_stream_if.sv
hdl/ppc_cell.sv
hdl/ppc_eval.sv
hdl/polygon_point_containment.sv
hdl/ppc_checker.sv
sim/polygon_point_containment_test.sv
